// File: rtl/sct_pkg.sv
// shared types for the set cover tracker: operation codes and control/status bundles
`default_nettype none

package sct_pkg;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_ADD    = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic apply;
		logic walk_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_row;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/sct_ctrl.sv
// sequencer for one request: lookup, apply, row walk, result hand-off
`default_nettype none

module sct_ctrl
	import sct_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      in_stall
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_APPLY,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: state_q <= ST_APPLY;
				ST_APPLY:  state_q <= ST_WALK;
				ST_WALK: begin
					if (sts.last_row) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.lookup   = (state_q == ST_LOOKUP);
		cmd.apply    = (state_q == ST_APPLY);
		cmd.walk_rd  = (state_q == ST_WALK);
		cmd.out_load = (state_q == ST_FINISH) && !sts.out_busy;
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/sct_datapath.sv
// column store, solution state, row cover count walk and result register
`default_nettype none

module sct_datapath
	import sct_pkg::*;
#(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 256,
	parameter int COST_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  column,
	input  wire logic [15:0] column_cost,
	input  wire logic [63:0] row_mask,
	input  wire logic [6:0]  active_rows,
	input  wire logic [8:0]  active_columns,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic [23:0]      total_cost,
	output logic [6:0]       uncovered_count,
	output logic             all_covered,
	output logic             rejected
);

	// only 256 columns are addressable through the 8-bit column field
	localparam int COL_DEPTH = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
	localparam int CI_W      = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
	localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_INC,
		MODE_DEC
	} mode_t;

	// captured request
	op_t                  op_q;
	logic [7:0]           column_q;
	logic [COST_BITS-1:0] cost_q;
	logic [MAX_ROWS-1:0]  mask_q;

	// column store
	logic [MAX_ROWS-1:0]  mask_mem [COL_DEPTH];
	logic [COST_BITS-1:0] cost_mem [COL_DEPTH];
	logic [MAX_ROWS-1:0]  mask_rd_q;
	logic [COST_BITS-1:0] cost_rd_q;

	// solution state
	logic [COL_DEPTH-1:0] in_use_q;
	logic [23:0]          total_q;
	logic                 rejected_q;
	mode_t                mode_q;

	// row walk
	logic [8:0]           cnt_mem [MAX_ROWS];
	logic [8:0]           cnt_rd_q;
	logic [MAX_ROWS-1:0]  row_vld_q;
	logic [RW-1:0]        rd_idx_q;
	logic [RW-1:0]        row_s1;
	logic                 walk_s1;
	logic [6:0]           unc_q;

	// result register
	logic                 out_valid_q;
	logic [23:0]          out_total_q;
	logic [6:0]           out_unc_q;
	logic                 out_all_q;
	logic                 out_rej_q;

	logic [CI_W-1:0]      col_idx;
	logic                 in_range;
	logic                 reject_now;
	logic [31:0]          cost_wide;
	logic [23:0]          cost24;
	logic [6:0]           rows_lim;
	logic [8:0]           cnt_cur;
	logic [8:0]           cnt_new;
	logic                 hit;
	logic                 row_active;

	assign col_idx  = column_q[CI_W-1:0];
	assign in_range = ({1'b0, column_q} < active_columns) &&
		({24'd0, column_q} < 32'(MAX_COLUMNS));

	always_comb begin
		unique case (op_q)
			OP_CLEAR:         reject_now = 1'b0;
			OP_LOAD, OP_ADD:  reject_now = !in_range || in_use_q[col_idx];
			OP_REMOVE:        reject_now = !in_range || !in_use_q[col_idx];
			default:          reject_now = 1'b1;
		endcase
	end

	assign cost_wide = 32'(cost_rd_q);
	assign cost24    = cost_wide[23:0];

	assign rows_lim   = (active_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : active_rows;
	assign cnt_cur    = row_vld_q[row_s1] ? cnt_rd_q : 9'd0;
	assign hit        = mask_rd_q[row_s1];
	assign row_active = (7'(row_s1) < rows_lim);

	always_comb begin
		unique case (mode_q)
			MODE_INC: cnt_new = hit ? cnt_cur + 9'd1 : cnt_cur;
			MODE_DEC: cnt_new = (hit && (cnt_cur != 9'd0)) ? cnt_cur - 9'd1 : cnt_cur;
			default:  cnt_new = cnt_cur;
		endcase
	end

	assign sts.last_row = (rd_idx_q == RW'(MAX_ROWS - 1));
	assign sts.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op_t'(op);
			column_q <= column;
			cost_q   <= COST_BITS'(column_cost);
			mask_q   <= MAX_ROWS'(row_mask);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			mask_rd_q <= mask_mem[col_idx];
			cost_rd_q <= cost_mem[col_idx];
		end
		if (cmd.apply && !reject_now && (op_q == OP_LOAD)) begin
			mask_mem[col_idx] <= mask_q;
			cost_mem[col_idx] <= cost_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_rd) cnt_rd_q <= cnt_mem[rd_idx_q];
		if (walk_s1) cnt_mem[row_s1] <= cnt_new;
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_rd) row_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= '0;
			total_q    <= '0;
			rejected_q <= 1'b0;
			mode_q     <= MODE_NONE;
			row_vld_q  <= '0;
			rd_idx_q   <= '0;
			walk_s1    <= 1'b0;
			unc_q      <= '0;
		end else begin
			walk_s1 <= cmd.walk_rd;
			if (cmd.walk_rd) rd_idx_q <= rd_idx_q + RW'(1);
			if (cmd.apply) begin
				rejected_q <= reject_now;
				mode_q     <= MODE_NONE;
				unc_q      <= '0;
				rd_idx_q   <= '0;
				if (!reject_now) begin
					unique case (op_q)
						OP_CLEAR: begin
							in_use_q  <= '0;
							total_q   <= '0;
							row_vld_q <= '0;
						end
						OP_ADD: begin
							in_use_q[col_idx] <= 1'b1;
							total_q           <= total_q + cost24;
							mode_q            <= MODE_INC;
						end
						OP_REMOVE: begin
							in_use_q[col_idx] <= 1'b0;
							total_q           <= total_q - cost24;
							mode_q            <= MODE_DEC;
						end
						default: begin
						end
					endcase
				end
			end
			if (walk_s1) begin
				row_vld_q[row_s1] <= 1'b1;
				if (row_active && (cnt_new == 9'd0)) unc_q <= unc_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_total_q <= total_q;
			out_unc_q   <= unc_q;
			out_all_q   <= (unc_q == 7'd0);
			out_rej_q   <= rejected_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign total_cost      = out_total_q;
	assign uncovered_count = out_unc_q;
	assign all_covered     = out_all_q;
	assign rejected        = out_rej_q;

endmodule

`default_nettype wire

// File: rtl/set_cover_solution_tracker.sv
// set cover solution tracker: keeps one instance and one candidate solution
// input channel in_valid/in_stall carries op, column, column_cost, row_mask;
// op loads a column, clears the solution, adds or removes a column.
// every request gives exactly one result on out_valid/out_stall: total cost,
// uncovered active rows, all_covered and a rejected flag.
// one request at a time: in_stall stays high from accept until the result is
// loaded into the output register, so no new request is taken before then; the
// wait is set by the walk over the row cover count memory, one row
// read-modify-write per cycle, for every request.
// the result sits in an output register, so the next request is accepted
// while the receiver stalls; a second result then waits until it is taken.
// apb registers: active_rows at 0x0 (reset 64), active_columns at 0x4
// (reset 256); write them only while no request is in flight.
// reset empties the solution; column costs and masks are undefined until
// loaded, and adding a never-loaded column is not allowed.
`default_nettype none

module set_cover_solution_tracker
	import sct_pkg::*;
#(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 256,
	parameter int COST_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  column,
	input  wire logic [15:0] column_cost,
	input  wire logic [63:0] row_mask,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [23:0]      total_cost,
	output logic [6:0]       uncovered_count,
	output logic             all_covered,
	output logic             rejected,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic REG_ACTIVE_ROWS    = 1'b0;
	localparam logic REG_ACTIVE_COLUMNS = 1'b1;

	logic [6:0] active_rows_q;
	logic [8:0] active_columns_q;
	logic       reg_idx;
	logic       reg_wr;
	cmd_t       cmd;
	sts_t       sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q    <= 7'd64;
			active_columns_q <= 9'd256;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_ACTIVE_ROWS:    active_rows_q    <= pwdata[6:0];
				REG_ACTIVE_COLUMNS: active_columns_q <= pwdata[8:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ACTIVE_ROWS:    prdata = {25'd0, active_rows_q};
			REG_ACTIVE_COLUMNS: prdata = {23'd0, active_columns_q};
			default:            prdata = '0;
		endcase
	end

	sct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	sct_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS),
		.COST_BITS   (COST_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.op              (op),
		.column          (column),
		.column_cost     (column_cost),
		.row_mask        (row_mask),
		.active_rows     (active_rows_q),
		.active_columns  (active_columns_q),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.total_cost      (total_cost),
		.uncovered_count (uncovered_count),
		.all_covered     (all_covered),
		.rejected        (rejected)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted but block not busy next cycle");

	a_unc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (uncovered_count <= 7'(MAX_ROWS)))
		else $error("uncovered count exceeds row capacity");

	a_all_covered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (all_covered == (uncovered_count == 7'd0)))
		else $error("all_covered disagrees with uncovered count");
`endif

endmodule

`default_nettype wire
